/* rtl/rrpc_pkg.sv */
// Shared types, constants and helpers for the rotated rectangle pixel counter.
`default_nettype none
package rrpc_pkg;

  localparam int unsigned ImageWidth = 640;
  localparam int unsigned CoordW     = 15;
  localparam int unsigned PixW       = 10;
  localparam int unsigned CountW     = 22;
  localparam int unsigned CountMax   = 4194303;
  localparam int unsigned XW         = 35;
  localparam int unsigned DivBits    = 34;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned NumEdges   = 4;

  localparam logic [2:0] RegCorner0X = 3'd0;

  typedef struct packed {
    logic [PixW-1:0] row;
    logic [PixW-1:0] col;
    logic            set;
    logic            last;
  } pix_t;

  typedef struct packed {
    logic signed [3:0][CoordW-1:0] x;
    logic signed [3:0][CoordW-1:0] y;
  } corners_t;

  typedef enum logic [3:0] {
    E_IDLE = 4'b0001,
    E_MUL1 = 4'b0010,
    E_MUL2 = 4'b0100,
    E_DIV  = 4'b1000
  } edge_state_e;

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_START = 4'b0010,
    B_WAIT  = 4'b0100,
    B_EVAL  = 4'b1000
  } back_state_e;

  // Edge k runs from corner edge_a(k) to corner edge_b(k): 0-1, 0-2, 1-3, 2-3.
  function automatic logic [1:0] edge_a(input logic [1:0] k);
    case (k)
      2'd0:    edge_a = 2'd0;
      2'd1:    edge_a = 2'd0;
      2'd2:    edge_a = 2'd1;
      default: edge_a = 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] edge_b(input logic [1:0] k);
    case (k)
      2'd0:    edge_b = 2'd1;
      2'd1:    edge_b = 2'd2;
      default: edge_b = 2'd3;
    endcase
  endfunction

endpackage
`default_nettype wire

/* rtl/rotated_rect_pixel_count_unit.sv */
// Top level: corner registers, front queue and back end of the pixel counter.
// A pixel that is not set, or whose row matches the cached row, goes straight to B_EVAL in the back end;
// a set pixel on a new row first runs the edge unit for every edge, one after another.
// The back end takes a new pixel only once it is through with the last; the serial divider sets the row cost.
// Result: inside_count is registered, with m_axis_tvalid, when B_EVAL retires the frame's last pixel.
// Reset (rst_ni low, asynchronous): corners 0, count 0, queue empty, edge cache invalid.
`default_nettype none
module rotated_rect_pixel_count_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // pixel_row, pixel_col, pixel_set, zero pad
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // inside_count, zero pad
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [14:0] cfg_data_i
);
  import rrpc_pkg::*;

  corners_t corners_q;
  pix_t     in_pix, q_pix;
  logic     q_valid, q_ready;
  logic     cfg_we;
  logic [CountW-1:0] count;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corners_q <= '0;
    end else if (cfg_we) begin
      if (cfg_index_i[0]) corners_q.y[cfg_index_i[2:1]] <= cfg_data_i;
      else                corners_q.x[cfg_index_i[2:1] - RegCorner0X[2:1]] <= cfg_data_i;
    end
  end

  assign in_pix.row  = s_axis_tdata[9:0];
  assign in_pix.col  = s_axis_tdata[19:10];
  assign in_pix.set  = s_axis_tdata[20];
  assign in_pix.last = s_axis_tlast;

  rrpc_fifo u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (in_pix),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_pix)
  );

  rrpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .corners_i   (corners_q),
    .cache_clr_i (cfg_we),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_data_i   (q_pix),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_count_o (count)
  );

  assign m_axis_tdata = {2'b00, count};

endmodule
`default_nettype wire

/* rtl/rrpc_fifo.sv */
// Front queue: accepts pixel transfers and buffers them for the back end.
`default_nettype none
module rrpc_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire rrpc_pkg::pix_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output rrpc_pkg::pix_t     out_data_o
);
  import rrpc_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);

  pix_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            push, pop;

  assign in_ready_o  = (cnt_q != (PtrW+1)'(FifoDepth));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign push        = in_valid_i & in_ready_o;
  assign pop         = out_valid_o & out_ready_i;

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/rrpc_edge_unit.sv */
// Edge x at a row: two multiplies, then a restoring divide one bit per cycle.
`default_nettype none
module rrpc_edge_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [rrpc_pkg::CoordW-1:0]  xa_i,
  input  wire logic signed [rrpc_pkg::CoordW-1:0]  ya_i,
  input  wire logic signed [rrpc_pkg::CoordW-1:0]  xb_i,
  input  wire logic signed [rrpc_pkg::CoordW-1:0]  yb_i,
  input  wire logic        [rrpc_pkg::PixW-1:0]    row_i,
  output logic                                     done_o,
  output logic                                     flat_o,
  output logic signed [rrpc_pkg::XW-1:0]           x_o
);
  import rrpc_pkg::*;

  edge_state_e state_q, state_d;
  logic signed [15:0]        dy_q, dx_q;
  logic signed [16:0]        t_q;
  logic signed [CoordW-1:0]  xa_q;
  logic signed [DivBits-1:0] acc_q;
  logic [DivBits-1:0]        quo_q;
  logic [20:0]               rem_q, den_q;
  logic                      neg_q, done_q;
  logic [5:0]                cnt_q;

  logic signed [30:0]        p1;
  logic signed [32:0]        p2;
  logic signed [DivBits-1:0] num;
  logic [20:0]               sh;
  logic                      ge;
  logic [15:0]               dy_abs;

  assign p1     = xa_q * dy_q;
  assign p2     = dx_q * t_q;
  assign num    = acc_q + DivBits'(p2);
  assign sh     = {rem_q[19:0], quo_q[DivBits-1]};
  assign ge     = (sh >= den_q);
  assign dy_abs = dy_q[15] ? 16'(-dy_q) : dy_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      E_IDLE:  if (start_i) state_d = E_MUL1;
      E_MUL1:  state_d = E_MUL2;
      E_MUL2:  state_d = E_DIV;
      E_DIV:   if (cnt_q == 6'(DivBits - 1)) state_d = E_IDLE;
      default: state_d = E_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == E_DIV) && (cnt_q == 6'(DivBits - 1));
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      E_IDLE: begin
        if (start_i) begin
          dy_q <= 16'(yb_i) - 16'(ya_i);
          dx_q <= 16'(xb_i) - 16'(xa_i);
          t_q  <= $signed({3'b000, row_i, 4'b0000}) - 17'(ya_i);
          xa_q <= xa_i;
        end
      end
      E_MUL1: acc_q <= DivBits'(p1);
      E_MUL2: begin
        neg_q <= num[DivBits-1] ^ dy_q[15];
        quo_q <= num[DivBits-1] ? DivBits'(-num) : DivBits'(num);
        den_q <= {1'b0, dy_abs, 4'b0000};
        rem_q <= '0;
        cnt_q <= '0;
      end
      E_DIV: begin
        rem_q <= ge ? sh - den_q : sh;
        quo_q <= {quo_q[DivBits-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign flat_o = (dy_q == '0);
  assign x_o    = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule
`default_nettype wire

/* rtl/rrpc_back.sv */
// Back end: per-row edge cache, band test, saturating count and result register.
`default_nettype none
module rrpc_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire rrpc_pkg::corners_t             corners_i,
  input  wire logic                           cache_clr_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire rrpc_pkg::pix_t                 in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [rrpc_pkg::CountW-1:0]         out_count_o
);
  import rrpc_pkg::*;

  back_state_e state_q, state_d;
  pix_t                   item_q;
  logic [1:0]             k_q;
  logic                   cache_ok_q;
  logic [PixW-1:0]        cache_row_q;
  logic signed [XW-1:0]   ex_q [NumEdges];
  logic [NumEdges-1:0]    flat_q;
  logic [CountW-1:0]      count_q;
  logic                   out_valid_q;
  logic [CountW-1:0]      out_count_q;

  logic                   eu_start, eu_done, eu_flat;
  logic signed [XW-1:0]   eu_x;
  logic                   need_calc, stall;
  logic [2:0]             hit;
  logic [CountW:0]        sum;
  logic [CountW-1:0]      new_count;

  rrpc_edge_unit u_edge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (eu_start),
    .xa_i    (corners_i.x[edge_a(k_q)]),
    .ya_i    (corners_i.y[edge_a(k_q)]),
    .xb_i    (corners_i.x[edge_b(k_q)]),
    .yb_i    (corners_i.y[edge_b(k_q)]),
    .row_i   (item_q.row),
    .done_o  (eu_done),
    .flat_o  (eu_flat),
    .x_o     (eu_x)
  );

  assign in_ready_o = (state_q == B_IDLE);
  assign eu_start   = (state_q == B_START);
  assign need_calc  = in_data_i.set & ~(cache_ok_q & (cache_row_q == in_data_i.row));
  assign stall      = item_q.last & out_valid_q & ~out_ready_i;

  // Band i uses corner rows i..i+1 and edges i, i+1.
  always_comb begin
    logic signed [CoordW-1:0] ya, yb, r16;
    logic signed [XW:0]       e0, e1, mn, mx, cc;
    logic                     rowok;
    for (int i = 0; i < 3; i++) begin
      ya    = corners_i.y[i];
      yb    = corners_i.y[i+1];
      r16   = $signed({1'b0, item_q.row, 4'b0000});
      rowok = (ya[CoordW-1] | (item_q.row >= ya[CoordW-2:4])) & (r16 < yb);
      e0    = (XW+1)'(ex_q[i]);
      e1    = (XW+1)'(ex_q[i+1]);
      mn    = (e0 < e1) ? e0 : e1;
      mx    = (e0 < e1) ? e1 : e0;
      cc    = $signed({{(XW+1-PixW){1'b0}}, item_q.col});
      hit[i] = item_q.set & rowok & ~flat_q[i] & ~flat_q[i+1] &
               (cc >= mn - 1) & (cc < mx + 1) &
               (item_q.col < PixW'(ImageWidth > 1023 ? 1023 : ImageWidth)) |
               (item_q.set & rowok & ~flat_q[i] & ~flat_q[i+1] &
                (cc >= mn - 1) & (cc < mx + 1) & (ImageWidth > 1023));
    end
  end

  always_comb begin
    sum = (CountW+1)'(count_q) + (CountW+1)'(hit[0]) + (CountW+1)'(hit[1])
        + (CountW+1)'(hit[2]);
    new_count = (sum > (CountW+1)'(CountMax)) ? CountW'(CountMax) : sum[CountW-1:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (in_valid_i) state_d = need_calc ? B_START : B_EVAL;
      B_START: state_d = B_WAIT;
      B_WAIT:  if (eu_done) state_d = (k_q == 2'(NumEdges - 1)) ? B_EVAL : B_START;
      B_EVAL:  if (!stall) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      k_q         <= '0;
      cache_ok_q  <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_EVAL && !stall && item_q.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == B_IDLE && in_valid_i && need_calc) k_q <= '0;
      if (state_q == B_WAIT && eu_done) k_q <= k_q + 1'b1;
      if (cache_clr_i) begin
        cache_ok_q <= 1'b0;
      end else if (state_q == B_WAIT && eu_done && k_q == 2'(NumEdges - 1)) begin
        cache_ok_q <= 1'b1;
      end
      if (state_q == B_EVAL && !stall) begin
        if (item_q.last) begin
          count_q <= '0;
        end else begin
          count_q <= new_count;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && in_valid_i) item_q <= in_data_i;
    if (state_q == B_WAIT && eu_done) begin
      ex_q[k_q]   <= eu_x;
      flat_q[k_q] <= eu_flat;
      cache_row_q <= item_q.row;
    end
    if (state_q == B_EVAL && !stall && item_q.last) out_count_q <= new_count;
  end

  assign out_valid_o = out_valid_q;
  assign out_count_o = out_count_q;

endmodule
`default_nettype wire

/* rtl/rrpc_checker.sv */
// Port-level checks for the pixel counter, bound to the top level.
`default_nettype none
module rrpc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:22] == 2'b00)
    else $error("result pad bits not zero");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind rotated_rect_pixel_count_unit rrpc_checker u_rrpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready_o   (cfg_ready_o)
);
`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for the rotated rectangle pixel counter: predicted frame counts.
`timescale 1ns / 1ps
module tb;
  import rrpc_pkg::*;

  localparam int unsigned RunLimit = 3000000;
  localparam int unsigned DrainCycles = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [14:0] cfg_data_i = '0;

  rotated_rect_pixel_count_unit dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  longint corner_x[4];
  longint corner_y[4];
  logic [CountW-1:0] frame_count;
  logic [CountW-1:0] counts_due[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  bit no_idle = 1'b0;
  int unsigned out_wait = 0;

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic bit edge_col(int a, int b, longint r, output longint xo);
    longint dy, dx, num, den;
    dy = corner_y[b] - corner_y[a];
    dx = corner_x[b] - corner_x[a];
    xo = 0;
    if (dy == 0) return 1'b0;
    num = corner_x[a] * dy + dx * (16 * r - corner_y[a]);
    den = 16 * dy;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    xo = num / den;
    return 1'b1;
  endfunction

  function automatic int band_hit(int ya, int yb, int e0a, int e0b, int e1a, int e1b,
                                  longint r, longint c);
    longint xa, xb, lo, hi;
    if (r < corner_y[ya] / 16 || 16 * r >= corner_y[yb]) return 0;
    if (!edge_col(e0a, e0b, r, xa)) return 0;
    if (!edge_col(e1a, e1b, r, xb)) return 0;
    lo = ((xa < xb) ? xa : xb) - 1;
    hi = ((xa < xb) ? xb : xa) + 1;
    if (lo < 0) lo = 0;
    if (hi > ImageWidth) hi = ImageWidth;
    return (c >= lo && c < hi) ? 1 : 0;
  endfunction

  function automatic void predict_pixel(logic [9:0] row, logic [9:0] col, bit set, bit last);
    int hits;
    longint sum;
    if (set) begin
      hits = band_hit(0, 1, 0, 1, 0, 2, row, col) + band_hit(1, 2, 0, 2, 1, 3, row, col)
           + band_hit(2, 3, 1, 3, 2, 3, row, col);
      sum = longint'(frame_count) + hits;
      frame_count = (sum > CountMax) ? CountW'(CountMax) : CountW'(sum);
    end
    if (last) begin
      counts_due.push_back(frame_count);
      frame_count = '0;
    end
  endfunction

  task automatic send_pixel(logic [9:0] row, logic [9:0] col, bit set, bit last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, set, col, row};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_pixel(row, col, set, last);
    sent++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [14:0] val);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx[0]) corner_y[idx >> 1] = longint'($signed(val));
    else corner_x[idx >> 1] = longint'($signed(val));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (counts_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_corners(int x0, int y0, int x1, int y1, int x2, int y2, int x3, int y3);
    wait_idle();
    write_reg(RegCorner0X + 3'd0, 15'(x0));
    write_reg(RegCorner0X + 3'd1, 15'(y0));
    write_reg(RegCorner0X + 3'd2, 15'(x1));
    write_reg(RegCorner0X + 3'd3, 15'(y1));
    write_reg(RegCorner0X + 3'd4, 15'(x2));
    write_reg(RegCorner0X + 3'd5, 15'(y2));
    write_reg(RegCorner0X + 3'd6, 15'(x3));
    write_reg(RegCorner0X + 3'd7, 15'(y3));
  endtask

  // Result checker with random back-pressure per result.
  always @(negedge clk_i) begin
    if (out_wait > 0) begin
      m_axis_tready <= 1'b0;
      out_wait <= out_wait - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > RunLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (counts_due.size() == 0) begin
        $display("%0t unexpected result: expected none actual %0d", $time,
                 m_axis_tdata[CountW-1:0]);
        errors++;
      end else begin
        if (m_axis_tdata[CountW-1:0] !== counts_due[0]) begin
          $display("%0t inside_count mismatch: expected %0d actual %0d", $time,
                   counts_due[0], m_axis_tdata[CountW-1:0]);
          errors++;
        end
        void'(counts_due.pop_front());
      end
      out_wait <= draw_gap();
    end
  end

  task automatic test_reset_state();
    send_pixel(10'd0, 10'd0, 1'b1, 1'b1);
    send_pixel(10'd1023, 10'd1023, 1'b1, 1'b1);
  endtask

  task automatic test_directed();
    // diamond with a boundary row shared by two bands
    set_corners(3200, 0, 0, 3208, 6400, 3300, 3200, 6400);
    send_pixel(10'd200, 10'd200, 1'b1, 1'b0);
    send_pixel(10'd200, 10'd200, 1'b0, 1'b0);
    send_pixel(10'd200, 10'd1023, 1'b1, 1'b0);
    send_pixel(10'd100, 10'd200, 1'b1, 1'b0);
    send_pixel(10'd0, 10'd200, 1'b1, 1'b0);
    send_pixel(10'd0, 10'd0, 1'b1, 1'b0);
    send_pixel(10'd300, 10'd639, 1'b1, 1'b0);
    send_pixel(10'd300, 10'd640, 1'b1, 1'b0);
    send_pixel(10'd1023, 10'd0, 1'b1, 1'b1);
    // flat band edges
    set_corners(0, 800, 6000, 800, 100, 4000, 6000, 4000);
    send_pixel(10'd50, 10'd100, 1'b1, 1'b0);
    send_pixel(10'd100, 10'd100, 1'b1, 1'b0);
    send_pixel(10'd260, 10'd100, 1'b1, 1'b1);
    // register extremes
    set_corners(-16384, -16384, 16383, -16384, -16384, 16383, 16383, 16383);
    send_pixel(10'd0, 10'd0, 1'b1, 1'b0);
    send_pixel(10'd1023, 10'd639, 1'b1, 1'b0);
    send_pixel(10'd512, 10'd300, 1'b1, 1'b1);
    set_corners(16383, -16384, -16384, 0, 16383, 0, -16384, 16383);
    send_pixel(10'd0, 10'd1, 1'b1, 1'b0);
    send_pixel(10'd1023, 10'd1023, 1'b1, 1'b1);
    // unsorted corners
    set_corners(900, 9000, 4000, 1000, 100, 5000, 2000, 200);
    send_pixel(10'd100, 10'd100, 1'b1, 1'b0);
    send_pixel(10'd300, 10'd100, 1'b1, 1'b1);
  endtask

  function automatic int clamp15(int v);
    return (v < -16384) ? -16384 : (v > 16383) ? 16383 : v;
  endfunction

  task automatic random_corners();
    int px[4], py[4];
    int ccx, ccy, ux, uy, k, t, i, j;
    ccx = $urandom_range(0, 12000) - 1000;
    ccy = $urandom_range(0, 16000);
    ux = $urandom_range(0, 4000) - 2000;
    uy = $urandom_range(0, 4000) - 2000;
    k = $urandom_range(1, 8);
    px[0] = ccx + ux - uy * k / 4; py[0] = ccy + uy + ux * k / 4;
    px[1] = ccx + ux + uy * k / 4; py[1] = ccy + uy - ux * k / 4;
    px[2] = ccx - ux - uy * k / 4; py[2] = ccy - uy + ux * k / 4;
    px[3] = ccx - ux + uy * k / 4; py[3] = ccy - uy - ux * k / 4;
    if ($urandom_range(0, 9) != 0) begin
      for (i = 0; i < 3; i++)
        for (j = 0; j < 3 - i; j++)
          if (py[j] > py[j+1]) begin
            t = py[j]; py[j] = py[j+1]; py[j+1] = t;
            t = px[j]; px[j] = px[j+1]; px[j+1] = t;
          end
    end
    set_corners(clamp15(px[0]), clamp15(py[0]), clamp15(px[1]), clamp15(py[1]),
                clamp15(px[2]), clamp15(py[2]), clamp15(px[3]), clamp15(py[3]));
  endtask

  task automatic test_random_frames();
    int n, i, row, lo_row, hi_row;
    bit wide;
    while (sent < 1300) begin
      if ($urandom_range(0, 7) == 0) random_corners();
      no_idle = ($urandom_range(0, 3) == 0);
      wide = ($urandom_range(0, 5) == 0);
      lo_row = corner_y[0] / 16;
      hi_row = corner_y[3] / 16;
      if (lo_row < 0) lo_row = 0;
      if (hi_row > 1023) hi_row = 1023;
      if (hi_row < lo_row) hi_row = lo_row;
      row = wide ? $urandom_range(0, 1023) : $urandom_range(lo_row, hi_row);
      n = $urandom_range(1, 40);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 7) == 0)
          row = wide ? $urandom_range(0, 1023) : $urandom_range(lo_row, hi_row);
        send_pixel(10'(row), wide ? 10'($urandom_range(0, 1023)) : 10'($urandom_range(0, 700)),
                   $urandom_range(0, 4) != 0, i == n - 1);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < 4; i++) begin
      corner_x[i] = 0;
      corner_y[i] = 0;
    end
    frame_count = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_directed();
    test_random_frames();
    wait_idle();
    if (errors == 0 && counts_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
